[sv/gecf_pkg.sv]
// Shared types, constants and saturation helpers for the gyro/encoder
// complementary filter. No dependencies; every other file imports it.
package gecf_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 16;
  localparam int COEF_FRAC   = 15;
  localparam int STATE_W     = 40;
  localparam int OUT_W       = 32;
  localparam int VALUE_SHIFT = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Multiplier operand is split into an unsigned low part and a signed high part.
  localparam int OP_W   = STATE_W + 1;
  localparam int LO_W   = 21;
  localparam int HI_W   = OP_W - LO_W;
  localparam int MUL_W  = LO_W + 1;
  localparam int PROD_W = MUL_W + COEF_W + 1;
  localparam int ACC_W  = 58;
  localparam int RND_W  = ACC_W - COEF_FRAC;
  localparam int SUM_W  = RND_W + 1;

  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1 << COEF_FRAC);
  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(1 << (COEF_FRAC - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COEF   = CFG_IDX_W'(0),
    REG_WEIGHT_ONE    = CFG_IDX_W'(1),
    REG_WEIGHT_TWO    = CFG_IDX_W'(2),
    REG_ONE_SIDED     = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_w;
  } coef_set_t;

  typedef struct packed {
    logic en;
    logic hi;
  } mul_ctl_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:STATE_W-1]) || !(|v[SUM_W-1:STATE_W-1]);
    if (fits) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:OUT_W-1]) || !(|v[SUM_W-1:OUT_W-1]);
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

[sv/gecf_if.sv]
// Valid/ready channel interfaces for sample requests, results and register writes.
// Depends on gecf_pkg for field widths.
interface gecf_in_if import gecf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] gyro_sample;
  logic signed [SAMPLE_W-1:0] encoder_sample;
  modport source (output valid, output gyro_sample, output encoder_sample, input ready);
  modport sink   (input valid, input gyro_sample, input encoder_sample, output ready);
endinterface

interface gecf_out_if import gecf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] fused_value;
  modport source (output valid, output fused_value, input ready);
  modport sink   (input valid, input fused_value, output ready);
endinterface

interface gecf_cfg_if import gecf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/gecf_cfg_regs.sv]
// Configuration registers with coefficient clamping and weight selection.
// Depends on gecf_pkg and gecf_cfg_if.
module gecf_cfg_regs import gecf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gecf_cfg_if.sink    cfg_chan,
  output coef_set_t   coefs
);

  logic [COEF_W-1:0] coef_a_r;
  logic [COEF_W-1:0] weight_one_r;
  logic [COEF_W-1:0] weight_two_r;
  logic              one_sided_r;
  logic [COEF_W-1:0] weight_sel;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= COEF_RESET;
      weight_one_r <= COEF_RESET;
      weight_two_r <= COEF_RESET;
      one_sided_r  <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_FILTER_COEF: coef_a_r     <= cfg_chan.data;
        REG_WEIGHT_ONE:  weight_one_r <= cfg_chan.data;
        REG_WEIGHT_TWO:  weight_two_r <= cfg_chan.data;
        REG_ONE_SIDED:   one_sided_r  <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  assign weight_sel   = one_sided_r ? weight_one_r : weight_two_r;
  assign coefs.coef_a = (coef_a_r > COEF_ONE) ? COEF_ONE : coef_a_r;
  assign coefs.coef_w = (weight_sel > COEF_ONE) ? COEF_ONE : weight_sel;

endmodule

[sv/gecf_mul_unit.sv]
// Shared multiply-accumulate unit: a wide operand times a Q1.15 coefficient
// in two partial products, then round half up. Depends on gecf_pkg.
module gecf_mul_unit import gecf_pkg::*; (
  input  logic                     clk,
  input  mul_ctl_t                 ctl,
  input  logic signed [OP_W-1:0]   operand,
  input  logic [COEF_W-1:0]        coef,
  output logic signed [RND_W-1:0]  rounded
);

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [COEF_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_half;

  always_comb begin
    if (ctl.hi) begin
      mul_a = MUL_W'(signed'(operand[OP_W-1:LO_W]));
    end else begin
      mul_a = signed'({1'b0, operand[LO_W-1:0]});
    end
    mul_b = signed'({1'b0, coef});
    prod  = mul_a * mul_b;
    if (ctl.hi) begin
      acc_nxt = acc_r + (ACC_W'(prod) <<< LO_W);
    end else begin
      acc_nxt = ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_half = acc_r + ACC_W'(1 << (COEF_FRAC - 1));
  assign rounded  = acc_half[ACC_W-1:COEF_FRAC];

endmodule

[sv/gyro_encoder_complementary_filter_core.sv]
// Gyro high-pass / encoder low-pass complementary filter, top level.
// Each accepted request runs through six multiplier passes and two combine steps; the
// last step waits for a free output register, and only then is the next request taken.
// A result waits in an output register while the next request is taken.
// Synchronous active-low reset clears filter state to zero and restores the
// register defaults.
module gyro_encoder_complementary_filter_core import gecf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gecf_in_if.sink    in_chan,
  gecf_out_if.source out_chan,
  gecf_cfg_if.sink   cfg_chan
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HP_LO, ST_HP_HI, ST_LP_LO, ST_LP_HI, ST_LP_END,
    ST_FU_LO, ST_FU_HI, ST_FU_END
  } state_t;

  state_t                      state_r;
  coef_set_t                   coefs;
  mul_ctl_t                    mul_ctl;
  logic signed [OP_W-1:0]      operand;
  logic [COEF_W-1:0]           coef_sel;
  logic signed [RND_W-1:0]     rounded;

  logic signed [SAMPLE_W-1:0]  gyro_r;
  logic signed [SAMPLE_W-1:0]  enc_r;
  logic signed [SAMPLE_W-1:0]  gyro_last_r;
  logic signed [STATE_W-1:0]   gyro_filt_r;
  logic signed [STATE_W-1:0]   enc_filt_r;
  logic signed [STATE_W-1:0]   hp_r;
  logic signed [STATE_W-1:0]   lp_r;
  logic                        out_valid_r;
  logic signed [OUT_W-1:0]     out_data_r;

  logic signed [SAMPLE_W:0]    gyro_diff;
  logic signed [OP_W-1:0]      op_hp;
  logic signed [OP_W-1:0]      op_lp;
  logic signed [OP_W-1:0]      op_fu;
  logic                        out_free;

  gecf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .coefs    (coefs)
  );

  gecf_mul_unit u_mul (
    .clk     (clk),
    .ctl     (mul_ctl),
    .operand (operand),
    .coef    (coef_sel),
    .rounded (rounded)
  );

  assign gyro_diff = (SAMPLE_W+1)'(gyro_r) - (SAMPLE_W+1)'(gyro_last_r);
  assign op_hp     = OP_W'(gyro_filt_r) + (OP_W'(gyro_diff) <<< VALUE_SHIFT);
  assign op_lp     = OP_W'(enc_filt_r) - (OP_W'(enc_r) <<< VALUE_SHIFT);
  assign op_fu     = OP_W'(hp_r) - OP_W'(lp_r);
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    operand  = op_hp;
    coef_sel = coefs.coef_a;
    mul_ctl  = '0;
    unique case (state_r)
      ST_HP_LO: mul_ctl = '{en: 1'b1, hi: 1'b0};
      ST_HP_HI: mul_ctl = '{en: 1'b1, hi: 1'b1};
      ST_LP_LO: begin
        operand = op_lp;
        mul_ctl = '{en: 1'b1, hi: 1'b0};
      end
      ST_LP_HI: begin
        operand = op_lp;
        mul_ctl = '{en: 1'b1, hi: 1'b1};
      end
      ST_FU_LO: begin
        operand  = op_fu;
        coef_sel = coefs.coef_w;
        mul_ctl  = '{en: 1'b1, hi: 1'b0};
      end
      ST_FU_HI: begin
        operand  = op_fu;
        coef_sel = coefs.coef_w;
        mul_ctl  = '{en: 1'b1, hi: 1'b1};
      end
      default: ;
    endcase
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.fused_value = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gyro_last_r <= '0;
      gyro_filt_r <= '0;
      enc_filt_r  <= '0;
    end else begin
      if (state_r == ST_FU_END && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            gyro_r  <= in_chan.gyro_sample;
            enc_r   <= in_chan.encoder_sample;
            state_r <= ST_HP_LO;
          end
        end
        ST_HP_LO: state_r <= ST_HP_HI;
        ST_HP_HI: state_r <= ST_LP_LO;
        ST_LP_LO: begin
          hp_r    <= sat_state(SUM_W'(rounded));
          state_r <= ST_LP_HI;
        end
        ST_LP_HI: state_r <= ST_LP_END;
        ST_LP_END: begin
          lp_r    <= sat_state((SUM_W'(enc_r) <<< VALUE_SHIFT) + SUM_W'(rounded));
          state_r <= ST_FU_LO;
        end
        ST_FU_LO: state_r <= ST_FU_HI;
        ST_FU_HI: state_r <= ST_FU_END;
        ST_FU_END: begin
          if (out_free) begin
            out_data_r  <= sat_out(SUM_W'(lp_r) + SUM_W'(rounded));
            gyro_filt_r <= hp_r;
            gyro_last_r <= gyro_r;
            enc_filt_r  <= lp_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
